FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on the rising clock edge, masked while reset is high.
`define RPLS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on the rising clock edge, also during reset.
`define RPLS_ASSERT_NR(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rpls_pkg.sv
package rpls_pkg;

   localparam int MaxVarsDef = 8;
   localparam int AccW       = 72;
   localparam int OneQ16     = 65536;
   localparam int DivNumW    = 48;
   localparam int DivDenW    = 33;

   // action / result kind codes
   localparam logic ActUpdate  = 1'b0;
   localparam logic ActPredict = 1'b1;

   // register indexes
   localparam logic [1:0] CsrForget = 2'd0;
   localparam logic [1:0] CsrVars   = 2'd1;
   localparam logic [1:0] CsrEnable = 2'd2;

   localparam logic [16:0] ForgetRst = 17'd62259;
   localparam logic [3:0]  VarsRst   = 4'd8;

   localparam logic signed [AccW-1:0] SatHi = AccW'(2147483647);
   localparam logic signed [AccW-1:0] SatLo = -SatHi - AccW'(1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_PRED_MUL, S_PRED_ACC, S_PRED_OUT,
      S_BL_OLD, S_BL_NEW, S_BL_SUM, S_BL_WB, S_PQ_MUL, S_PQ_RND,
      S_SS_MUL, S_SS_ADD, S_ROOT_GO, S_ROOT_WAIT, S_WDIV_GO, S_WDIV_WAIT,
      S_T_MUL, S_T_ACC, S_T_RND, S_QDIV_GO, S_QDIV_WAIT, S_CF_MUL, S_CF_WB,
      S_DONE
   } state_type;

   typedef enum logic {BlendMean, BlendCov} blend_mode_type;

   function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
      logic signed [31:0] r;
      if (v > SatHi) r = 32'sh7FFF_FFFF;
      else if (v < SatLo) r = 32'sh8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // round half up to Q16.16, then saturate
   function automatic logic signed [31:0] rnd_sat32(input logic signed [AccW-1:0] v);
      logic signed [AccW-1:0] t;
      t = (v + AccW'(32768)) >>> 16;
      return sat32(t);
   endfunction

   function automatic logic [31:0] abs32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   // signed, saturated value of a quotient magnitude
   function automatic logic signed [31:0] quo_sat(input logic [DivNumW:0] q, input logic neg);
      logic signed [31:0] r;
      if (neg) begin
         if (q > (DivNumW+1)'(33'h8000_0000)) r = 32'sh8000_0000;
         else r = -$signed(q[31:0]);
      end else begin
         if (q > (DivNumW+1)'(32'h7FFF_FFFF)) r = 32'sh7FFF_FFFF;
         else r = $signed(q[31:0]);
      end
      return r;
   endfunction

endpackage

FILE: sv/rpls_div.sv
module rpls_div import rpls_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [DivNumW-1:0] num,
   input  logic [DivDenW-1:0] den,
   output logic               done,
   output logic [DivNumW:0]   quo
);
   localparam int NW = DivNumW + 1;
   localparam int CntW = $clog2(NW + 1);

   logic [NW-1:0]      dvd_ff;
   logic [DivDenW-1:0] rem_ff;
   logic [DivDenW-1:0] den_ff;
   logic [CntW-1:0]    cnt_ff;
   logic               run_ff;
   logic               done_ff;
   logic [DivDenW:0]   trial;
   logic               fits;

   assign trial = {rem_ff, dvd_ff[NW-1]};
   assign fits  = trial >= {1'b0, den_ff};

   // one quotient bit a cycle; quotient shifts into the dividend register
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            dvd_ff <= NW'(num) + NW'(den >> 1);
            rem_ff <= '0;
            den_ff <= den;
            cnt_ff <= CntW'(NW);
            run_ff <= 1'b1;
         end else if (run_ff) begin
            rem_ff <= fits ? DivDenW'(trial - {1'b0, den_ff}) : trial[DivDenW-1:0];
            dvd_ff <= {dvd_ff[NW-2:0], fits};
            cnt_ff <= cnt_ff - CntW'(1);
            if (cnt_ff == CntW'(1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = dvd_ff;
endmodule

FILE: sv/rpls_sqrt.sv
module rpls_sqrt import rpls_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);
   logic [63:0] v_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic        run_ff;
   logic        done_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   // shift-and-subtract root: each step yields one root bit from two radicand bits
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            v_ff   <= value;
            res_ff <= '0;
            bit_ff <= 64'h4000_0000_0000_0000;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            if (v_ff >= trial) begin
               v_ff   <= v_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            if (bit_ff == 64'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule

FILE: sv/recursive_pls_updater_top.sv
// Recursive PLS updater, Q16.16. Feed one sample element per word with start
// while busy is low; last marks the final element, action picks update or
// predict. A predict element inside the variable count runs through the
// multiply and accumulate states; other non-final elements are taken while
// idle. A final update element runs the whole model refresh on one shared
// 33x33 multiplier plus a radix-2 divider and a root unit, with nv variables;
// the covariance walk and the per-weight divisions dominate its run. After
// reset a clearing pass zeroes all MAX_VARS*MAX_VARS covariance memory words,
// with busy high. Each result shows on the rsp_ ports for exactly one
// cycle with rsp_valid; the receiver cannot stall, so capture it then.
// Write the csr_ registers only while the block is idle.
`include "assert_macros.svh"

module recursive_pls_updater_top import rpls_pkg::*; #(
   parameter int MAX_VARS = MaxVarsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic signed [31:0] req_x_value,
   input  logic signed [31:0] req_y_value,
   input  logic               req_last,
   output logic               rsp_valid,
   output logic               rsp_result_kind,
   output logic signed [31:0] rsp_result_value,
   output logic [31:0]        rsp_updates_done,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_wdata
);
   localparam int IW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
   localparam int CW = $clog2(MAX_VARS + 1);
   localparam int MD = MAX_VARS * MAX_VARS;
   localparam int AW = (MD > 1) ? $clog2(MD) : 1;
   localparam logic signed [AccW-1:0] P48Hi = AccW'(48'sh7FFF_FFFF_FFFF);
   localparam logic signed [AccW-1:0] P48Lo = -P48Hi - AccW'(1);

   // configuration
   logic [16:0] forget_ff;
   logic [3:0]  vars_ff;
   logic        enable_ff;

   // model state
   logic signed [31:0] mean_ff  [MAX_VARS];
   logic signed [31:0] cxy_ff   [MAX_VARS];
   logic signed [31:0] w_ff     [MAX_VARS];
   logic signed [31:0] coef_ff  [MAX_VARS];
   logic signed [31:0] sb_ff    [MAX_VARS];
   logic signed [31:0] dx_ff    [MAX_VARS];
   logic signed [31:0] ymean_ff;
   logic signed [31:0] q_ff;
   logic signed [31:0] dy_ff;
   logic signed [31:0] p_ff;
   logic signed [31:0] t_ff;
   logic signed [47:0] pacc_ff;
   logic [3:0]         elem_ff;
   logic [31:0]        cnt_ff;
   logic signed [31:0] cov_mem [MD];
   logic signed [31:0] cov_rd_ff;

   // sequencer
   state_type          state_ff, state_in;
   blend_mode_type     mode_ff;
   logic [CW-1:0]      i_ff, j_ff;
   logic [AW-1:0]      clr_ff;
   logic [IW-1:0]      pidx_ff;
   logic               plast_ff;
   logic signed [31:0] x_ff, y_ff;
   logic signed [65:0] prod_ff;
   logic signed [AccW-1:0] acc_ff;
   logic [63:0]        ss_ff;
   logic [31:0]        norm_ff;

   // output word
   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic signed [31:0] rsp_value_ff;

   // combinational
   logic [CW-1:0]      nv;
   logic [16:0]        lam;
   logic [CW-1:0]      i_next;
   logic               i_last;
   logic               j_var;
   logic               i_var;
   logic               accept;
   logic               in_range;
   logic [IW-1:0]      ii, jj;
   logic [AW-1:0]      cov_addr;
   logic signed [31:0] blend_old, blend_new;
   logic signed [32:0] mul_a, mul_b;
   logic signed [31:0] acc_r;
   logic signed [31:0] prod_r;
   logic signed [31:0] diff;
   logic signed [AccW-1:0] pacc_sum;
   logic [64:0]        ss_sum;
   logic               mem_we;
   logic [AW-1:0]      mem_wa;
   logic signed [31:0] mem_wd;
   logic               div_start, div_done;
   logic [DivNumW-1:0] div_num;
   logic [DivDenW-1:0] div_den;
   logic [DivNumW:0]   div_quo;
   logic               div_neg;
   logic               sqrt_start, sqrt_done;
   logic [31:0]        sqrt_root;

   always_comb begin
      if (vars_ff == 4'd0) nv = CW'(1);
      else if (32'(vars_ff) > 32'(MAX_VARS)) nv = CW'(MAX_VARS);
      else nv = CW'(vars_ff);
   end

   assign lam      = (forget_ff > 17'(OneQ16)) ? 17'(OneQ16) : forget_ff;
   assign i_next   = i_ff + CW'(1);
   assign i_last   = (i_next == nv);
   assign i_var    = (i_ff != nv);
   assign j_var    = (j_ff != nv);
   assign ii       = IW'(i_ff);
   assign jj       = IW'(j_ff);
   assign cov_addr = AW'(32'(i_ff) * MAX_VARS + 32'(j_ff));
   assign busy     = (state_ff != S_IDLE);
   assign accept   = start && !busy;
   assign in_range = 32'(elem_ff) < 32'(nv);
   assign acc_r    = rnd_sat32(acc_ff);
   assign prod_r   = rnd_sat32(AccW'(prod_ff));
   assign diff     = sat32(AccW'(x_ff) - AccW'(mean_ff[pidx_ff]));
   assign pacc_sum = ((AccW'(prod_ff) + AccW'(32768)) >>> 16) + AccW'(pacc_ff);
   assign ss_sum   = {1'b0, ss_ff} + {1'b0, prod_ff[63:0]};

   // blend operands: means first, then covariances
   always_comb begin
      if (mode_ff == BlendMean) begin
         blend_old = i_var ? mean_ff[ii] : ymean_ff;
         blend_new = i_var ? sb_ff[ii] : y_ff;
      end else begin
         blend_old = j_var ? cov_rd_ff : cxy_ff[ii];
         blend_new = p_ff;
      end
   end

   // next state, multiplier operands, unit starts, memory write
   always_comb begin
      state_in   = state_ff;
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      div_num    = '0;
      div_den    = '0;
      div_neg    = 1'b0;
      sqrt_start = 1'b0;
      mem_we     = 1'b0;
      mem_wa     = cov_addr;
      mem_wd     = acc_r;
      case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
            if (clr_ff == AW'(MD - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               if (req_action == ActPredict && in_range) state_in = S_PRED_MUL;
               else if (req_last && req_action == ActPredict) state_in = S_PRED_OUT;
               else if (req_last) state_in = S_BL_OLD;
            end
         end
         S_PRED_MUL: begin
            mul_a    = 33'(coef_ff[pidx_ff]);
            mul_b    = 33'(diff);
            state_in = S_PRED_ACC;
         end
         S_PRED_ACC: state_in = plast_ff ? S_PRED_OUT : S_IDLE;
         S_PRED_OUT: state_in = S_IDLE;
         S_BL_OLD: begin
            mul_a    = 33'(lam);
            mul_b    = 33'(blend_old);
            state_in = S_BL_NEW;
         end
         S_BL_NEW: begin
            mul_a    = 33'(17'(OneQ16) - lam);
            mul_b    = 33'(blend_new);
            state_in = S_BL_SUM;
         end
         S_BL_SUM: state_in = S_BL_WB;
         S_BL_WB: begin
            if (mode_ff == BlendMean) begin
               state_in = i_var ? S_BL_OLD : S_PQ_MUL;
            end else begin
               mem_we = j_var;
               if (j_var) state_in = S_PQ_MUL;
               else state_in = i_last ? S_SS_MUL : S_PQ_MUL;
            end
         end
         S_PQ_MUL: begin
            mul_a    = 33'(dx_ff[ii]);
            mul_b    = j_var ? 33'(dx_ff[jj]) : 33'(dy_ff);
            state_in = S_PQ_RND;
         end
         S_PQ_RND: state_in = S_BL_OLD;
         S_SS_MUL: begin
            mul_a    = 33'(cxy_ff[ii]);
            mul_b    = 33'(cxy_ff[ii]);
            state_in = S_SS_ADD;
         end
         S_SS_ADD: state_in = i_last ? S_ROOT_GO : S_SS_MUL;
         S_ROOT_GO: begin
            sqrt_start = 1'b1;
            state_in   = S_ROOT_WAIT;
         end
         S_ROOT_WAIT: if (sqrt_done) state_in = S_WDIV_GO;
         S_WDIV_GO: begin
            div_start = 1'b1;
            div_num   = {abs32(cxy_ff[ii]), 16'b0};
            div_den   = {1'b0, norm_ff};
            state_in  = S_WDIV_WAIT;
         end
         S_WDIV_WAIT: begin
            div_neg = cxy_ff[ii][31];
            if (div_done) begin
               if (!i_last) state_in = S_WDIV_GO;
               else state_in = enable_ff ? S_T_MUL : S_DONE;
            end
         end
         S_T_MUL: begin
            mul_a    = 33'(w_ff[ii]);
            mul_b    = 33'(dx_ff[ii]);
            state_in = S_T_ACC;
         end
         S_T_ACC: state_in = i_last ? S_T_RND : S_T_MUL;
         S_T_RND: state_in = (acc_r == 32'sd0) ? S_CF_MUL : S_QDIV_GO;
         S_QDIV_GO: begin
            div_start = 1'b1;
            div_num   = {abs32(dy_ff), 16'b0};
            div_den   = {1'b0, abs32(t_ff)};
            state_in  = S_QDIV_WAIT;
         end
         S_QDIV_WAIT: begin
            div_neg = dy_ff[31] ^ t_ff[31];
            if (div_done) state_in = S_CF_MUL;
         end
         S_CF_MUL: begin
            mul_a    = 33'(w_ff[ii]);
            mul_b    = 33'(q_ff);
            state_in = S_CF_WB;
         end
         S_CF_WB: state_in = i_last ? S_DONE : S_CF_MUL;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else state_ff <= state_in;
   end

   // shared multiplier, registered
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // covariance memory
   always_ff @(posedge clock) begin
      if (mem_we) cov_mem[mem_wa] <= mem_wd;
      cov_rd_ff <= cov_mem[cov_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         forget_ff <= ForgetRst;
         vars_ff   <= VarsRst;
         enable_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_index)
            CsrForget: forget_ff <= csr_wdata;
            CsrVars:   vars_ff   <= csr_wdata[3:0];
            CsrEnable: enable_ff <= csr_wdata[0];
            default:   ;
         endcase
      end
   end

   // sample buffer: no reset, written by update elements
   always_ff @(posedge clock) begin
      if (accept && req_action == ActUpdate && in_range) sb_ff[IW'(elem_ff)] <= req_x_value;
   end

   // datapath and control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MAX_VARS; k++) begin
            mean_ff[k] <= '0;
            cxy_ff[k]  <= '0;
            w_ff[k]    <= '0;
            coef_ff[k] <= '0;
         end
         ymean_ff     <= '0;
         q_ff         <= '0;
         pacc_ff      <= '0;
         elem_ff      <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         mode_ff      <= BlendMean;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: clr_ff <= clr_ff + AW'(1);
            S_IDLE: begin
               if (accept) begin
                  x_ff     <= req_x_value;
                  y_ff     <= req_y_value;
                  pidx_ff  <= IW'(elem_ff);
                  plast_ff <= req_last;
                  if (req_last) elem_ff <= '0;
                  else if (elem_ff != 4'd15) elem_ff <= elem_ff + 4'd1;
                  if (req_last && req_action == ActUpdate) begin
                     pacc_ff <= '0;
                     i_ff    <= '0;
                     j_ff    <= '0;
                     mode_ff <= BlendMean;
                  end
               end
            end
            S_PRED_ACC: begin
               if (pacc_sum > P48Hi) pacc_ff <= P48Hi[47:0];
               else if (pacc_sum < P48Lo) pacc_ff <= P48Lo[47:0];
               else pacc_ff <= pacc_sum[47:0];
            end
            S_PRED_OUT: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= ActPredict;
               rsp_value_ff <= sat32(AccW'(ymean_ff) + AccW'(pacc_ff));
               pacc_ff      <= '0;
            end
            S_BL_NEW: acc_ff <= AccW'(prod_ff);
            S_BL_SUM: acc_ff <= acc_ff + AccW'(prod_ff);
            S_BL_WB: begin
               if (mode_ff == BlendMean) begin
                  if (i_var) begin
                     mean_ff[ii] <= acc_r;
                     dx_ff[ii]   <= sat32(AccW'(sb_ff[ii]) - AccW'(acc_r));
                     i_ff        <= i_next;
                  end else begin
                     ymean_ff <= acc_r;
                     dy_ff    <= sat32(AccW'(y_ff) - AccW'(acc_r));
                     i_ff     <= '0;
                     j_ff     <= '0;
                     mode_ff  <= BlendCov;
                  end
               end else if (j_var) begin
                  j_ff <= j_ff + CW'(1);
               end else begin
                  cxy_ff[ii] <= acc_r;
                  j_ff       <= '0;
                  i_ff       <= i_last ? '0 : i_next;
                  ss_ff      <= '0;
               end
            end
            S_PQ_RND: p_ff <= prod_r;
            S_SS_ADD: begin
               ss_ff <= ss_sum[64] ? '1 : ss_sum[63:0];
               i_ff  <= i_last ? '0 : i_next;
            end
            S_ROOT_WAIT: begin
               if (sqrt_done) norm_ff <= (sqrt_root == 32'd0) ? 32'd1 : sqrt_root;
            end
            S_WDIV_WAIT: begin
               if (div_done) begin
                  w_ff[ii] <= quo_sat(div_quo, div_neg);
                  i_ff     <= i_last ? '0 : i_next;
                  acc_ff   <= '0;
               end
            end
            S_T_ACC: begin
               acc_ff <= acc_ff + AccW'(prod_ff);
               i_ff   <= i_last ? '0 : i_next;
            end
            S_T_RND: begin
               t_ff <= acc_r;
               if (acc_r == 32'sd0) q_ff <= '0;
            end
            S_QDIV_WAIT: if (div_done) q_ff <= quo_sat(div_quo, div_neg);
            S_CF_WB: begin
               coef_ff[ii] <= sat32(AccW'(coef_ff[ii]) + AccW'(prod_r));
               i_ff        <= i_last ? '0 : i_next;
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               rsp_kind_ff  <= ActUpdate;
               rsp_value_ff <= q_ff;
               if (cnt_ff != 32'hFFFF_FFFF) cnt_ff <= cnt_ff + 32'd1;
            end
            default: ;
         endcase
      end
   end

   rpls_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   rpls_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (ss_ff),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = rsp_kind_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_updates_done = cnt_ff;

   `RPLS_ASSERT(a_upd_counted, clock, reset, (rsp_valid && rsp_result_kind == ActUpdate) |-> (rsp_updates_done != 32'd0), "update word with zero count")
   `RPLS_ASSERT(a_sqrt_when_wait, clock, reset, sqrt_done |-> (state_ff == S_ROOT_WAIT), "root finished outside its wait")
   `RPLS_ASSERT(a_div_when_wait, clock, reset, div_done |-> (state_ff == S_WDIV_WAIT || state_ff == S_QDIV_WAIT), "quotient finished outside a wait")
   `RPLS_ASSERT(a_no_rsp_clear, clock, reset, rsp_valid |-> ($past(state_ff) != S_CLEAR), "word during clearing pass")
endmodule

FILE: bench/recursive_pls_updater_top_tb.sv
`timescale 1ns / 100ps

module recursive_pls_updater_top_tb;
   import rpls_pkg::*;

   localparam int NVARS      = 8;
   localparam int SETTLE_CYC = 1200;   // longer than one full update refresh

   typedef struct {
      logic        kind;
      logic [31:0] value;
      logic [31:0] count;
   } rsp_word_type;

   typedef struct {
      logic         act;
      logic [31:0]  x;
      logic [31:0]  y;
      logic         lst;
      bit           typed;   // expectation written in the row itself
      rsp_word_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_action = 1'b0;
   logic [31:0] req_x_value = '0;
   logic [31:0] req_y_value = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_result_kind;
   logic [31:0] rsp_result_value;
   logic [31:0] rsp_updates_done;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [16:0] csr_wdata = '0;

   recursive_pls_updater_top DUT (.*);

   always #2 clock = ~clock;

   // Model state, mirrored word by word.
   longint          m_lam, m_vars, m_en;
   longint          m_xmean [NVARS];
   longint          m_cxx   [NVARS*NVARS];
   longint          m_cxy   [NVARS];
   longint          m_w     [NVARS];
   longint          m_b     [NVARS];
   longint          m_sbuf  [NVARS];
   longint          m_ymean, m_q, m_pacc;
   int              m_idx;
   int unsigned     m_count;

   rsp_word_type    pending_rsp [$];
   stim_row_type    table_rows [$];
   int              err_cnt = 0;
   int              n_upd = 0, n_pred = 0, n_words = 0;

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint clip48(longint v);
      longint hi;
      hi = (64'sd1 <<< 47) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // round half up, then floor shift
   function automatic longint rnd_shift(longint v, int s);
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clip32(rnd_shift(a * b, 16));
   endfunction

   function automatic longint mix(longint lam, longint old, longint nw);
      return clip32(rnd_shift(lam * old + (64'sd65536 - lam) * nw, 16));
   endfunction

   // nearest, halves away from zero
   function automatic longint div_near(longint num, longint den);
      longint unsigned n, d, q;
      longint r;
      n = num < 0 ? -num : num;
      d = den < 0 ? -den : den;
      q = (n + d / 2) / d;
      r = (q > 64'h3FFF_FFFF_FFFF_FFFF) ? 64'sh3FFF_FFFF_FFFF_FFFF : longint'(q);
      return ((num < 0) != (den < 0)) ? -r : r;
   endfunction

   function automatic longint unsigned int_root(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic int active_vars();
      if (m_vars < 1) return 1;
      if (m_vars > NVARS) return NVARS;
      return int'(m_vars);
   endfunction

   // Fold one target into means, covariances, weights and coefficients.
   function automatic void refresh_model(longint y);
      longint lam, dy, t;
      longint dx [NVARS];
      longint unsigned ss, sq, norm;
      int nv;
      lam = m_lam > 65536 ? 65536 : m_lam;
      nv = active_vars();
      t = 0;
      ss = 0;
      for (int i = 0; i < nv; i++) begin
         m_xmean[i] = mix(lam, m_xmean[i], m_sbuf[i]);
         dx[i] = clip32(m_sbuf[i] - m_xmean[i]);
      end
      m_ymean = mix(lam, m_ymean, y);
      dy = clip32(y - m_ymean);
      for (int i = 0; i < nv; i++) begin
         for (int j = 0; j < nv; j++)
            m_cxx[i*NVARS+j] = mix(lam, m_cxx[i*NVARS+j], qmul(dx[i], dx[j]));
         m_cxy[i] = mix(lam, m_cxy[i], qmul(dx[i], dy));
      end
      for (int i = 0; i < nv; i++) begin
         sq = longint'(m_cxy[i] * m_cxy[i]);
         ss = (ss > ~64'd0 - sq) ? ~64'd0 : ss + sq;
      end
      norm = int_root(ss);
      if (norm < 1) norm = 1;
      for (int i = 0; i < nv; i++)
         m_w[i] = clip32(div_near(m_cxy[i] * 65536, longint'(norm)));
      if (m_en[0]) begin
         for (int i = 0; i < nv; i++) t += m_w[i] * dx[i];
         t = clip32(rnd_shift(t, 16));
         m_q = (t == 0) ? 0 : clip32(div_near(dy * 65536, t));
         for (int i = 0; i < nv; i++) m_b[i] = clip32(m_b[i] + qmul(m_w[i], m_q));
      end
      if (m_count != 32'hFFFF_FFFF) m_count++;
   endfunction

   // Advance the model by one accepted word; returns 1 when a result follows.
   function automatic bit model_word(logic act, logic [31:0] xw, logic [31:0] yw,
                                     logic lst, output rsp_word_type r);
      longint x, y, diff;
      x = longint'($signed(xw));
      y = longint'($signed(yw));
      r = '{default: '0};
      if (m_idx < active_vars()) begin
         if (act == ActUpdate) begin
            m_sbuf[m_idx] = x;
         end else begin
            diff = clip32(x - m_xmean[m_idx]);
            m_pacc = clip48(m_pacc + rnd_shift(m_b[m_idx] * diff, 16));
         end
      end
      if (!lst) begin
         if (m_idx < 15) m_idx++;
         return 0;
      end
      m_idx = 0;
      if (act == ActPredict) begin
         r.kind = ActPredict;
         r.value = 32'(clip32(m_ymean + m_pacc));
         m_pacc = 0;
      end else begin
         m_pacc = 0;
         refresh_model(y);
         r.kind = ActUpdate;
         r.value = 32'(m_q);
      end
      r.count = m_count;
      return 1;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      err_cnt++;
   endtask

   // Check every strobed result against the oldest expectation.
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected result", rsp_result_value, '0);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_result_kind !== e.kind)
               report_mismatch("kind", 32'(rsp_result_kind), 32'(e.kind));
            if (rsp_result_value !== e.value) report_mismatch("value", rsp_result_value, e.value);
            if (rsp_updates_done !== e.count) report_mismatch("count", rsp_updates_done, e.count);
            if (e.kind == ActUpdate) n_upd++; else n_pred++;
         end
      end
   end

   // Hold start with the word until busy drops at an edge; gaps are mostly short.
   task automatic send_word(logic act, logic [31:0] x, logic [31:0] y, logic lst,
                            bit typed, rsp_word_type want);
      int gap;
      rsp_word_type r;
      gap = ($urandom_range(0, 9) < 5) ? 0 :
            ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_action  <= act;
      req_x_value <= x;
      req_y_value <= y;
      req_last    <= lst;
      do @(posedge clock); while (busy);
      n_words++;
      if (model_word(act, x, y, lst, r)) pending_rsp.push_back(typed ? want : r);
   endtask

   // Drain outstanding results, then let any trailing work finish.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [16:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CsrForget: m_lam  = val;
         CsrVars:   m_vars = val[3:0];
         CsrEnable: m_en   = val[0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] rand_q16();
      case ($urandom_range(0, 7))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3, 4: return $urandom;
         default: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      endcase
   endfunction

   function automatic void add_row(logic act, logic [31:0] x, logic [31:0] y, logic lst,
                                   bit typed = 1'b0, logic kind = 1'b0,
                                   logic [31:0] val = '0, logic [31:0] cnt = '0);
      table_rows.push_back('{act, x, y, lst, typed, '{kind, val, cnt}});
   endfunction

   initial begin
      #40ms;
      $display("[recursive_pls_updater_top] ERROR");
      $finish;
   end

   initial begin
      rsp_word_type none;
      int nv, len;
      logic vec_act;
      bit mixed;
      none = '{default: '0};
      m_lam = ForgetRst; m_vars = VarsRst; m_en = 1;
      m_ymean = 0; m_q = 0; m_pacc = 0; m_idx = 0; m_count = 0;
      for (int i = 0; i < NVARS; i++) begin
         m_xmean[i] = 0; m_cxy[i] = 0; m_w[i] = 0; m_b[i] = 0; m_sbuf[i] = 0;
      end
      for (int i = 0; i < NVARS*NVARS; i++) m_cxx[i] = 0;

      // Directed: predictions on a cleared model, a zero-score update,
      // extreme samples, extra elements and mixed actions.
      add_row(ActPredict, 32'h0, 32'h0, 1'b1, 1'b1, ActPredict, 32'h0, 32'd0);
      add_row(ActPredict, 32'h7FFF_FFFF, 32'h0, 1'b0);
      add_row(ActPredict, 32'h8000_0000, 32'h0, 1'b0);
      add_row(ActPredict, 32'd123, 32'h7FFF_FFFF, 1'b1, 1'b1, ActPredict, 32'h0, 32'd0);
      for (int i = 0; i < NVARS; i++)
         add_row(ActUpdate, 32'h0, 32'h0, i == NVARS-1, 1'b1, ActUpdate, 32'h0, 32'd1);
      for (int i = 0; i < NVARS; i++)
         add_row(ActUpdate, i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, 32'h8000_0000,
                 i == NVARS-1);
      for (int i = 0; i < NVARS + 1; i++)
         add_row(ActUpdate, 32'(i << 16), 32'h7FFF_FFFF, i == NVARS);
      for (int i = 0; i < NVARS; i++)
         add_row(i[0] ? ActUpdate : ActPredict, 32'hFFFF_0000, 32'h1234_5678,
                 i == NVARS-1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      foreach (table_rows[k])
         send_word(table_rows[k].act, table_rows[k].x, table_rows[k].y, table_rows[k].lst,
                   table_rows[k].typed, table_rows[k].want);

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 8; ph++) begin
         wait_idle();
         case (ph)
            0: begin write_csr(CsrForget, 17'd0);      write_csr(CsrVars, 17'd1);
                     write_csr(CsrEnable, 17'd1); end
            1: begin write_csr(CsrForget, 17'd65536);  write_csr(CsrVars, 17'd8); end
            2: begin write_csr(CsrForget, 17'h1FFFF);  write_csr(CsrVars, 17'd0); end
            3: begin write_csr(CsrForget, 17'd62259);  write_csr(CsrVars, 17'd15);
                     write_csr(CsrEnable, 17'd0); end
            4: begin write_csr(CsrVars, 17'd3);         write_csr(CsrEnable, 17'd1); end
            default: begin
               write_csr(CsrForget, 17'($urandom_range(0, 65536)));
               write_csr(CsrVars, 17'($urandom_range(1, 8)));
               write_csr(CsrEnable, 17'($urandom_range(0, 1)));
            end
         endcase
         csr_we <= 1'b0;
         nv = active_vars();
         while (n_words < 30 + (ph + 1) * 215) begin
            // mostly well-formed vectors; some short, long or mixed
            len = ($urandom_range(0, 9) < 7) ? nv : $urandom_range(1, nv + 3);
            vec_act = 1'($urandom_range(0, 1));
            mixed = ($urandom_range(0, 9) == 0);
            for (int e = 0; e < len; e++)
               send_word(mixed ? 1'($urandom_range(0, 1)) : vec_act, rand_q16(),
                         rand_q16(), e == len - 1, 1'b0, none);
         end
      end

      wait_idle();
      $display("covered %0d words: %0d update and %0d prediction results checked",
               n_words, n_upd, n_pred);
      $display("register settings swept across forgetting extremes, 1..8 vars, enable on/off");
      if (err_cnt == 0) begin
         $display("[recursive_pls_updater_top] OK");
      end else begin
         $display("[recursive_pls_updater_top] ERROR");
      end
      $finish;
   end

endmodule
